// ===== sv/aarm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared types and constants for the axis-angle rotation matrix generator.
// ----------------------------------------------------------------------------
package aarm_pkg;

    // Defaults for the top-level parameters
    localparam int DATA_WIDTH_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Q2.14 one and the index of the homogeneous row
    localparam logic [15:0] ONE_Q14  = 16'h4000;
    localparam logic [1:0]  ROW_LAST = 2'd3;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Input beat
    typedef struct packed {
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic        [15:0] angle;
    } t_in;

    // Output beat
    typedef struct packed {
        logic        [1:0]  row;
        logic signed [15:0] col0;
        logic signed [15:0] col1;
        logic signed [15:0] col2;
        logic signed [15:0] col3;
        logic               last;
    } t_out;

    // 3x3 rotation part, entry (k,j) at index 3*k+j
    typedef logic [8:0][15:0] t_mat9;

endpackage

// ===== sv/aarm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic
// Pipelined rotation-mode CORDIC: one register stage per iteration, then
// quadrant fold and clamp. Carries the axis alongside.
// ----------------------------------------------------------------------------
module aarm_cordic #(
    parameter int DATA_WIDTH   = aarm_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  aarm_pkg::t_in                i_item,
    output logic                         o_valid,
    output aarm_pkg::t_in                o_item,
    output logic signed [DATA_WIDTH-1:0] o_cos,
    output logic signed [DATA_WIDTH-1:0] o_sin
);
    localparam int F  = DATA_WIDTH - 2;
    localparam int XW = DATA_WIDTH + 2;
    localparam int ZW = 32;
    localparam logic [63:0] X_INIT64 =
        (64'd1304065748 + (64'd1 << (30 - F))) >> (31 - F);
    localparam logic signed [XW-1:0] X_INIT = X_INIT64[XW-1:0];
    localparam logic signed [XW-1:0] LIM    = XW'(1) << F;

    logic signed [XW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [XW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    logic        [1:0]    r_q [0:CORDIC_STEPS];
    aarm_pkg::t_in        r_it[0:CORDIC_STEPS];
    logic                 r_v [0:CORDIC_STEPS];

    logic [15:0] angle_off;
    logic [1:0]  n_q;
    logic [15:0] resid;

    // Quadrant split of the angle
    assign angle_off = i_item.angle + 16'h2000;
    assign n_q       = angle_off[15:14];
    assign resid     = i_item.angle - {n_q, 14'd0};

    // Entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]  <= X_INIT;
        r_y[0]  <= '0;
        r_z[0]  <= {resid, 16'd0};
        r_q[0]  <= n_q;
        r_it[0] <= i_item;
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam logic signed [ZW-1:0] ATAN = aarm_pkg::ATAN_TURN32[k];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            if (!r_z[k][ZW-1]) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - ATAN;
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + ATAN;
            end
            r_q[k+1]  <= r_q[k];
            r_it[k+1] <= r_it[k];
        end
    end

    // Quadrant fold and clamp to [-1, 1]
    logic signed [XW-1:0] fx, fy, cx, cy;
    always_comb begin
        case (r_q[CORDIC_STEPS])
            2'd0: begin fx = r_x[CORDIC_STEPS];  fy = r_y[CORDIC_STEPS];  end
            2'd1: begin fx = -r_y[CORDIC_STEPS]; fy = r_x[CORDIC_STEPS];  end
            2'd2: begin fx = -r_x[CORDIC_STEPS]; fy = -r_y[CORDIC_STEPS]; end
            default: begin fx = r_y[CORDIC_STEPS]; fy = -r_x[CORDIC_STEPS]; end
        endcase
        cx = (fx > LIM) ? LIM : ((fx < -LIM) ? -LIM : fx);
        cy = (fy > LIM) ? LIM : ((fy < -LIM) ? -LIM : fy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[CORDIC_STEPS];
        end
        o_cos  <= cx[DATA_WIDTH-1:0];
        o_sin  <= cy[DATA_WIDTH-1:0];
        o_item <= r_it[CORDIC_STEPS];
    end

endmodule

// ===== sv/aarm_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_matrix
// Three-stage datapath forming the 3x3 rotation part from axis, cos, sin:
// axis products, products with (1-c), then sum, round and saturate.
// ----------------------------------------------------------------------------
module aarm_matrix #(
    parameter int DATA_WIDTH = aarm_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  aarm_pkg::t_in                i_item,
    input  logic signed [DATA_WIDTH-1:0] i_cos,
    input  logic signed [DATA_WIDTH-1:0] i_sin,
    output logic                         o_valid,
    output aarm_pkg::t_mat9              o_mat
);
    localparam int F  = DATA_WIDTH - 2;
    localparam int PW = 32;
    localparam int SW = DATA_WIDTH + 16;
    localparam int CW = DATA_WIDTH + 1;
    localparam int MW = PW + CW;
    localparam int EW = MW + 2;
    localparam logic signed [EW-1:0] RND  = EW'(1) << (13 + F);
    localparam logic signed [EW-1:0] QMAX = EW'(32767);
    localparam logic signed [EW-1:0] QMIN = -EW'(32768);

    // Round half up to Q2.14 and saturate
    function automatic logic [15:0] to_q14(input logic signed [EW-1:0] a,
                                           input logic signed [EW-1:0] b);
        logic signed [EW-1:0] v;
        logic signed [EW-1:0] r;
        v = a + b + RND;
        r = v >>> (14 + F);
        if (r > QMAX) begin
            r = QMAX;
        end else if (r < QMIN) begin
            r = QMIN;
        end
        return r[15:0];
    endfunction

    // Stage 1: axis products, sin products, 1-c
    logic                   r_v1;
    logic signed [PW-1:0]   r_xx, r_xy, r_xz, r_yy, r_yz, r_zz;
    logic signed [SW-1:0]   r_sx, r_sy, r_sz;
    logic signed [CW-1:0]   r_cm;
    logic signed [DATA_WIDTH-1:0] r_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_xx <= i_item.axis_x * i_item.axis_x;
        r_xy <= i_item.axis_x * i_item.axis_y;
        r_xz <= i_item.axis_x * i_item.axis_z;
        r_yy <= i_item.axis_y * i_item.axis_y;
        r_yz <= i_item.axis_y * i_item.axis_z;
        r_zz <= i_item.axis_z * i_item.axis_z;
        r_sx <= SW'(i_sin) * SW'(i_item.axis_x);
        r_sy <= SW'(i_sin) * SW'(i_item.axis_y);
        r_sz <= SW'(i_sin) * SW'(i_item.axis_z);
        r_cm <= (CW'(1) << F) - CW'(i_cos);
        r_c1 <= i_cos;
    end

    // Stage 2: products with (1-c)
    logic                 r_v2;
    logic signed [MW-1:0] r_mxx, r_mxy, r_mxz, r_myy, r_myz, r_mzz;
    logic signed [SW-1:0] r_sx2, r_sy2, r_sz2;
    logic signed [DATA_WIDTH-1:0] r_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_mxx <= MW'(r_xx) * MW'(r_cm);
        r_mxy <= MW'(r_xy) * MW'(r_cm);
        r_mxz <= MW'(r_xz) * MW'(r_cm);
        r_myy <= MW'(r_yy) * MW'(r_cm);
        r_myz <= MW'(r_yz) * MW'(r_cm);
        r_mzz <= MW'(r_zz) * MW'(r_cm);
        r_sx2 <= r_sx;
        r_sy2 <= r_sy;
        r_sz2 <= r_sz;
        r_c2  <= r_c1;
    end

    // Stage 3: add the sin or cos term, round, saturate
    logic signed [EW-1:0] ct, tx, ty, tz;
    assign ct = EW'(r_c2) <<< 28;
    assign tx = EW'(r_sx2) <<< 14;
    assign ty = EW'(r_sy2) <<< 14;
    assign tz = EW'(r_sz2) <<< 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
        o_mat[0] <= to_q14(EW'(r_mxx), ct);
        o_mat[1] <= to_q14(EW'(r_mxy), -tz);
        o_mat[2] <= to_q14(EW'(r_mxz), ty);
        o_mat[3] <= to_q14(EW'(r_mxy), tz);
        o_mat[4] <= to_q14(EW'(r_myy), ct);
        o_mat[5] <= to_q14(EW'(r_myz), -tx);
        o_mat[6] <= to_q14(EW'(r_mxz), -ty);
        o_mat[7] <= to_q14(EW'(r_myz), tx);
        o_mat[8] <= to_q14(EW'(r_mzz), ct);
    end

endmodule

// ===== sv/aarm_rowser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_rowser
// Row serializer: holds one matrix and sends it as four row beats.
// ----------------------------------------------------------------------------
module aarm_rowser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  aarm_pkg::t_mat9 i_mat,
    output logic            o_valid,
    output aarm_pkg::t_out  o_result
);
    logic            r_act;
    logic [1:0]      r_cnt;
    aarm_pkg::t_mat9 r_mat;

    // Load on a new matrix, else step through the rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_cnt <= '0;
        end else if (i_valid) begin
            r_act <= 1'b1;
            r_cnt <= '0;
        end else if (r_act) begin
            r_cnt <= r_cnt + 2'd1;
            r_act <= (r_cnt != aarm_pkg::ROW_LAST);
        end
        if (i_valid) begin
            r_mat <= i_mat;
        end
    end

    // Row select
    always_comb begin
        o_valid       = r_act;
        o_result.row  = r_cnt;
        o_result.last = (r_cnt == aarm_pkg::ROW_LAST);
        case (r_cnt)
            2'd0: begin
                o_result.col0 = r_mat[0];
                o_result.col1 = r_mat[1];
                o_result.col2 = r_mat[2];
                o_result.col3 = '0;
            end
            2'd1: begin
                o_result.col0 = r_mat[3];
                o_result.col1 = r_mat[4];
                o_result.col2 = r_mat[5];
                o_result.col3 = '0;
            end
            2'd2: begin
                o_result.col0 = r_mat[6];
                o_result.col1 = r_mat[7];
                o_result.col2 = r_mat[8];
                o_result.col3 = '0;
            end
            default: begin
                o_result.col0 = '0;
                o_result.col1 = '0;
                o_result.col2 = '0;
                o_result.col3 = aarm_pkg::ONE_Q14;
            end
        endcase
    end

endmodule

// ===== sv/axis_angle_rotation_matrix_top.sv =====
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low; busy then stays high
// while r_gap counts down, so commands are spaced to the pace of the
// four-row output beat. The first row is on the ports after the entry
// register, which loads at the command edge, one register per CORDIC
// iteration, fold, three multiply and round stages and the row buffer, and is
// taken at the edge that ends its cycle. Rows 0..3 follow on consecutive
// cycles with o_valid high; row 3 carries last.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_top
// Axis plus angle in, 4x4 homogeneous rotation matrix out as row beats.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_top #(
    parameter int DATA_WIDTH   = aarm_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STEPS = aarm_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  aarm_pkg::t_in  i_item,
    output logic           o_valid,
    output aarm_pkg::t_out o_result
);
    logic [1:0] r_gap;
    logic       accept;

    logic                         cor_v;
    aarm_pkg::t_in                cor_item;
    logic signed [DATA_WIDTH-1:0] cor_c, cor_s;
    logic                         mat_v;
    aarm_pkg::t_mat9              mat;

    // Command spacing
    assign accept = start && !busy;
    assign busy   = (r_gap != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= 2'd3;
        end else if (busy) begin
            r_gap <= r_gap - 2'd1;
        end
    end

    aarm_cordic #(
        .DATA_WIDTH  (DATA_WIDTH),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(accept),
        .i_item (i_item),
        .o_valid(cor_v),
        .o_item (cor_item),
        .o_cos  (cor_c),
        .o_sin  (cor_s)
    );

    aarm_matrix #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_matrix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(cor_v),
        .i_item (cor_item),
        .i_cos  (cor_c),
        .i_sin  (cor_s),
        .o_valid(mat_v),
        .o_mat  (mat)
    );

    aarm_rowser u_rowser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mat_v),
        .i_mat   (mat),
        .o_valid (o_valid),
        .o_result(o_result)
    );

`ifndef SYNTH
    // Rows of one matrix come on consecutive cycles
    a_rows_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |=> o_valid)
        else $error("row beats of a matrix not contiguous");

    // A row other than row 0 follows a row beat
    a_row_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.row != 2'd0) |-> $past(o_valid))
        else $error("row beat without predecessor");

    // Last marks the homogeneous row only
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.last == (o_result.row == aarm_pkg::ROW_LAST)))
        else $error("last flag on wrong row");

    // A taken command raises busy for the command spacing
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy ##1 busy ##1 busy)
        else $error("command spacing broken");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the axis-angle rotation matrix generator: axis/angle commands go in
// under random gaps, each matrix row beat is compared with a locally computed
// CORDIC sine/cosine and fixed-point matrix.
// ----------------------------------------------------------------------------
module testbench;
    import aarm_pkg::*;

    localparam int FB    = DATA_WIDTH_DEF - 2;
    localparam int STEPS = CORDIC_STEPS_DEF;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_valid;
    t_out  o_result;
    int    n_errors;
    int    idle_pct;

    axis_angle_rotation_matrix_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic longint fshift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_q14(input longint v);
        longint r;
        r = fshift(v + (longint'(1) << (13 + FB)), 14 + FB);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // CORDIC sine/cosine with quadrant folding
    task automatic cordic_sincos(input logic [15:0] ang, output longint cs, output longint sn);
        logic [15:0] q16;
        logic [1:0]  quad;
        logic [15:0] resid;
        longint x, y, z, dx, dy, lim;
        q16   = ang + 16'h2000;
        quad  = q16[15:14];
        resid = ang - {quad, 14'd0};
        z = longint'($signed(resid)) * 65536;
        x = fshift(64'sd1304065748 + (longint'(1) << (30 - FB)), 31 - FB);
        y = 0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TURN32[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TURN32[i]);
            end
        end
        case (quad)
            2'd0: begin cs = x;  sn = y;  end
            2'd1: begin cs = -y; sn = x;  end
            2'd2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        lim = longint'(1) << FB;
        if (cs > lim) cs = lim;
        if (cs < -lim) cs = -lim;
        if (sn > lim) sn = lim;
        if (sn < -lim) sn = -lim;
    endtask

    class matrix_scoreboard;
        t_out pending_rows[$];

        // predict four row beats for one accepted command
        task note_command(input t_in cmd);
            longint ax, ay, az, c, s, cm, ct;
            longint m[9];
            t_out r;
            ax = cmd.axis_x; ay = cmd.axis_y; az = cmd.axis_z;
            cordic_sincos(cmd.angle, c, s);
            cm = (longint'(1) << FB) - c;
            ct = c * (longint'(1) << 28);
            m[0] = ax*ax*cm + ct;
            m[1] = ax*ay*cm - az*s*16384;
            m[2] = ax*az*cm + ay*s*16384;
            m[3] = ax*ay*cm + az*s*16384;
            m[4] = ay*ay*cm + ct;
            m[5] = ay*az*cm - ax*s*16384;
            m[6] = ax*az*cm - ay*s*16384;
            m[7] = ay*az*cm + ax*s*16384;
            m[8] = az*az*cm + ct;
            for (int k = 0; k < 4; k++) begin
                r.row  = k[1:0];
                r.col0 = (k < 3) ? 16'(round_q14(m[3*k]))   : '0;
                r.col1 = (k < 3) ? 16'(round_q14(m[3*k+1])) : '0;
                r.col2 = (k < 3) ? 16'(round_q14(m[3*k+2])) : '0;
                r.col3 = (k == 3) ? ONE_Q14 : '0;
                r.last = (k[1:0] == ROW_LAST);
                pending_rows.push_back(r);
            end
        endtask

        task check_row(input t_out got);
            t_out e;
            if (pending_rows.size() == 0) begin
                report($sformatf("unexpected row beat %p", got));
                return;
            end
            e = pending_rows.pop_front();
            if (got.row !== e.row)   report($sformatf("row %0d exp %0d", got.row, e.row));
            if (got.col0 !== e.col0) report($sformatf("row %0d col0 %0d exp %0d", e.row, got.col0, e.col0));
            if (got.col1 !== e.col1) report($sformatf("row %0d col1 %0d exp %0d", e.row, got.col1, e.col1));
            if (got.col2 !== e.col2) report($sformatf("row %0d col2 %0d exp %0d", e.row, got.col2, e.col2));
            if (got.col3 !== e.col3) report($sformatf("row %0d col3 %0d exp %0d", e.row, got.col3, e.col3));
            if (got.last !== e.last) report($sformatf("row %0d last %0b exp %0b", e.row, got.last, e.last));
        endtask
    endclass

    matrix_scoreboard sb;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watch both handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_command(i_item);
            if (o_valid) sb.check_row(o_result);
        end
    end

    // one command; start stays high back to back when no idle is drawn
    task automatic send_command(input t_in cmd);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_in rand_command();
        t_in c;
        logic [15:0] len;
        // mostly near-unit axes, sometimes full range
        len = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'h7FFF;
        c.axis_x = 16'($signed(16'($urandom_range(32767, 0))) - 16384) & len;
        c.axis_y = 16'($signed(16'($urandom_range(32767, 0))) - 16384) & len;
        c.axis_z = 16'($signed(16'($urandom_range(32767, 0))) - 16384) & len;
        if ($urandom_range(3, 0) == 0) begin
            c.axis_x = 16'($urandom);
            c.axis_y = 16'($urandom);
            c.axis_z = 16'($urandom);
        end
        c.angle = 16'($urandom);
        return c;
    endfunction

    function automatic t_in mk(input int x, input int y, input int z, input int a);
        t_in c;
        c.axis_x = 16'(x); c.axis_y = 16'(y); c.axis_z = 16'(z); c.angle = 16'(a);
        return c;
    endfunction

    initial begin
        int waited;
        sb       = new();
        n_errors = 0;
        idle_pct = 0;
        start    = 1'b0;
        i_item   = '0;
        i_rst_n  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;

        // directed: unit axes, zero axis, extremes, quadrant edges
        idle_pct = 26;
        send_command(mk(16384, 0, 0, 16'h0000));
        send_command(mk(0, 16384, 0, 16'h4000));
        send_command(mk(0, 0, 16384, 16'h8000));
        send_command(mk(0, 0, 16384, 16'hC000));
        send_command(mk(0, 0, 0, 16'h1234));
        send_command(mk(0, 0, 0, 16'h0000));
        send_command(mk(32767, 32767, 32767, 16'h2000));
        send_command(mk(-32768, -32768, -32768, 16'h1FFF));
        send_command(mk(32767, -32768, 0, 16'hFFFF));
        send_command(mk(-32768, 32767, -1, 16'h6000));
        send_command(mk(9459, 9459, 9459, 16'h5555));
        send_command(mk(-16384, 0, 0, 16'hE000));
        send_command(mk(11585, -11585, 0, 16'hDFFF));
        send_command(mk(1, -1, 1, 16'hA000));
        send_command(mk(0, 0, 0, 16'h4000));

        // random, three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 26 : (ph == 1) ? 83 : 0;
            for (int n = 0; n < 100; n++) send_command(rand_command());
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending_rows.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (STEPS + 20) @(posedge i_clk);
        if (sb.pending_rows.size() != 0)
            report($sformatf("%0d row beats never arrived", sb.pending_rows.size()));
        if (n_errors == 0)
            $display("axis_angle_rotation_matrix_top regression: pass");
        else
            $display("axis_angle_rotation_matrix_top regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("axis_angle_rotation_matrix_top regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
sv/aarm_pkg.sv
sv/aarm_cordic.sv
sv/aarm_matrix.sv
sv/aarm_rowser.sv
sv/axis_angle_rotation_matrix_top.sv
dv/testbench.sv
